// ===== design/tle_pkg.sv =====
// Shared types and constants for the terminal line editor.
// No dependencies; used by tle_ctrl, tle_dp and terminal_line_editor_unit.
package tle_pkg;

  // Default line capacity and width of the fill count
  localparam int LINE_DEPTH_DEF = 32;
  localparam int FILL_W         = 6;

  // Terminal control characters
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_DEL  = 8'h7F;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Escape skip phase codes
  localparam logic [1:0] ESC_OFF = 2'd0;
  localparam logic [1:0] ESC_ONE = 2'd1;
  localparam logic [1:0] ESC_TWO = 2'd2;

  // Result kind, carried on tuser
  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_EOL  = 2'd2
  } kind_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_EOL
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;      // input item accepted this cycle
    logic ptr_clr;   // restart line readout
    logic ptr_inc;   // step to next stored byte
    logic emit_cmd;  // load read byte as command result
    logic emit_eol;  // load end of line result, empty the line
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cr_hit;     // incoming byte is a carriage return outside an escape
    logic line_empty; // no stored bytes
    logic ptr_end;    // read pointer on newest stored byte
    logic out_free;   // output register can take a result
  } dp_stat_t;

endpackage

// ===== design/terminal_line_editor_unit.sv =====
// Terminal line editor: top level joining controller and datapath.
// Depends on tle_pkg, tle_ctrl and tle_dp.
//
// Usage: received terminal bytes enter on the s_ stream, one per item.
// Results leave on the m_ stream: tuser gives the kind (echo, command byte,
// end of line), tdata the byte, tlast marks the last result of an input item.
// Ordinary bytes, backspace and escape handling need no line readout; a result
// appears in the output register the cycle after the item is accepted.
// A carriage return holds s_tready low while the stored line is read out,
// byte by byte through the line memory's registered read port, followed by
// the end of line item. Bytes that give no result are taken at one item per
// cycle while the output register can take a result.
// Reset empties the line, ends any escape skip and drops a pending result.
// When the receiver stalls, the result waits in the output register and no
// new item is taken until it leaves.
module terminal_line_editor_unit #(
  parameter int LINE_DEPTH = tle_pkg::LINE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [1:0] out_kind
  output logic       m_tlast
);

  tle_pkg::dp_cmd_t  cmd;
  tle_pkg::dp_stat_t stat;
  tle_pkg::kind_t    out_kind;

  tle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .stat     (stat),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  tle_dp #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rx_byte   (s_tdata),
    .out_ready (m_tready),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_kind  (out_kind),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

  assign m_tuser = out_kind;

endmodule

// ===== design/tle_ctrl.sv =====
// Sequencer for the terminal line editor: input acceptance and line readout.
// Depends on tle_pkg.
module tle_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  tle_pkg::dp_stat_t stat,
  output logic              in_ready,
  output tle_pkg::dp_cmd_t  cmd
);

  tle_pkg::state_t state;
  tle_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tle_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tle_pkg::ST_IDLE: begin
        if (in_valid && stat.out_free && stat.cr_hit) begin
          state_next = stat.line_empty ? tle_pkg::ST_EOL : tle_pkg::ST_READ;
        end
      end
      tle_pkg::ST_READ: begin
        state_next = tle_pkg::ST_EMIT;
      end
      tle_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          state_next = stat.ptr_end ? tle_pkg::ST_EOL : tle_pkg::ST_READ;
        end
      end
      tle_pkg::ST_EOL: begin
        if (stat.out_free) begin
          state_next = tle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tle_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      tle_pkg::ST_IDLE: begin
        in_ready    = stat.out_free;
        cmd.take    = in_valid && stat.out_free;
        cmd.ptr_clr = 1'b1;
      end
      tle_pkg::ST_READ: begin
      end
      tle_pkg::ST_EMIT: begin
        cmd.emit_cmd = stat.out_free;
        cmd.ptr_inc  = stat.out_free && !stat.ptr_end;
      end
      tle_pkg::ST_EOL: begin
        cmd.emit_eol = stat.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/tle_dp.sv =====
// Datapath of the terminal line editor: line memory, fill count, escape
// phase and the result register. Depends on tle_pkg.
module tle_dp #(
  parameter int LINE_DEPTH = tle_pkg::LINE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  tle_pkg::dp_cmd_t  cmd,
  input  logic [7:0]        rx_byte,
  input  logic              out_ready,
  output tle_pkg::dp_stat_t stat,
  output logic              out_valid,
  output tle_pkg::kind_t    out_kind,
  output logic [7:0]        out_byte,
  output logic              out_last
);

  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam logic [tle_pkg::FILL_W-1:0] DEPTH_C = tle_pkg::FILL_W'(LINE_DEPTH);

  logic [7:0]                line_mem [LINE_DEPTH];
  logic [7:0]                rd_data;
  logic [AW-1:0]             rd_ptr;
  logic [tle_pkg::FILL_W-1:0] fill_count;
  logic [tle_pkg::FILL_W-1:0] fill_count_next;
  logic [1:0]                escape_phase;
  logic [1:0]                escape_phase_next;

  logic                      mem_we;
  logic                      echo_load;
  logic [7:0]                echo_byte;
  logic                      out_free;
  logic                      is_digit;
  logic [tle_pkg::FILL_W-1:0] fill_m1;

  assign out_free = !out_valid || out_ready;
  assign is_digit = (rx_byte >= tle_pkg::CH_ZERO) && (rx_byte <= tle_pkg::CH_NINE);
  assign fill_m1  = fill_count - tle_pkg::FILL_W'(1);

  // Status to the controller
  assign stat.cr_hit     = (escape_phase == tle_pkg::ESC_OFF) && (rx_byte == tle_pkg::CH_CR);
  assign stat.line_empty = (fill_count == '0);
  assign stat.ptr_end    = (tle_pkg::FILL_W'(rd_ptr) == fill_m1);
  assign stat.out_free   = out_free;

  // Per-byte edit decisions
  always_comb begin
    fill_count_next   = fill_count;
    escape_phase_next = escape_phase;
    mem_we            = 1'b0;
    echo_load         = 1'b0;
    echo_byte         = rx_byte;
    if (cmd.take) begin
      if (escape_phase != tle_pkg::ESC_OFF) begin
        // digits inside an escape do not count toward its end
        if (!is_digit) begin
          escape_phase_next = (escape_phase == tle_pkg::ESC_TWO) ?
                              tle_pkg::ESC_OFF : escape_phase + 2'd1;
        end
      end else if (rx_byte == tle_pkg::CH_NUL || rx_byte == tle_pkg::CH_CR) begin
        // zero is ignored; carriage return is run by the controller
      end else if (rx_byte == tle_pkg::CH_BS || rx_byte == tle_pkg::CH_DEL) begin
        if (fill_count != '0) begin
          fill_count_next = fill_m1;
          echo_load       = 1'b1;
          echo_byte       = tle_pkg::CH_DEL;
        end
      end else if (rx_byte == tle_pkg::CH_ESC) begin
        escape_phase_next = tle_pkg::ESC_ONE;
      end else if (fill_count < DEPTH_C) begin
        mem_we          = 1'b1;
        fill_count_next = fill_count + tle_pkg::FILL_W'(1);
        echo_load       = 1'b1;
      end
    end
    if (cmd.emit_eol) begin
      fill_count_next = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      escape_phase <= tle_pkg::ESC_OFF;
      out_valid    <= 1'b0;
    end else begin
      fill_count   <= fill_count_next;
      escape_phase <= escape_phase_next;
      if (echo_load || cmd.emit_cmd || cmd.emit_eol) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Read pointer for line readout
  always_ff @(posedge clk) begin
    if (cmd.ptr_clr) begin
      rd_ptr <= '0;
    end else if (cmd.ptr_inc) begin
      rd_ptr <= rd_ptr + AW'(1);
    end
  end

  // Line memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[fill_count[AW-1:0]] <= rx_byte;
    end
    rd_data <= line_mem[rd_ptr];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (echo_load) begin
      out_kind <= tle_pkg::KIND_ECHO;
      out_byte <= echo_byte;
      out_last <= 1'b1;
    end else if (cmd.emit_cmd) begin
      out_kind <= tle_pkg::KIND_CMD;
      out_byte <= rd_data;
      out_last <= 1'b0;
    end else if (cmd.emit_eol) begin
      out_kind <= tle_pkg::KIND_EOL;
      out_byte <= 8'h00;
      out_last <= 1'b1;
    end
  end

endmodule

// ===== verif/line_editor_checker.sv =====
`timescale 1ns / 1ps
// Checker for the terminal line editor: watches both streams, predicts the results.
// Depends on tle_pkg; instantiated by tb beside terminal_line_editor_unit.
module line_editor_checker #(
  parameter int LINE_DEPTH = tle_pkg::LINE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [7:0] out_byte
  input  logic [1:0] m_tuser,   // [1:0] out_kind
  input  logic       m_tlast,
  output int         fail_count,
  output int         pending
);

  typedef struct {
    tle_pkg::kind_t kind;
    logic [7:0]     data;
    logic           last;
  } editor_result_t;

  editor_result_t results_due[$];

  // Shadow of the editor state
  logic [1:0]  skip_phase = tle_pkg::ESC_OFF;
  logic [7:0]  line_copy [LINE_DEPTH];
  int unsigned line_len = 0;

  int mismatches = 0;
  int queued     = 0;

  assign fail_count = mismatches;
  assign pending    = queued;

  // Apply one received byte to the shadow state and queue what it produces
  function automatic void edit_line(input logic [7:0] b);
    if (skip_phase != tle_pkg::ESC_OFF) begin
      // digits inside an escape are swallowed without moving the phase
      if (!(b >= tle_pkg::CH_ZERO && b <= tle_pkg::CH_NINE))
        skip_phase = (skip_phase == tle_pkg::ESC_TWO) ?
                     tle_pkg::ESC_OFF : skip_phase + 2'd1;
    end else if (b == tle_pkg::CH_NUL) begin
      // zero byte is ignored
    end else if (b == tle_pkg::CH_BS || b == tle_pkg::CH_DEL) begin
      if (line_len != 0) begin
        line_len--;
        results_due.push_back('{tle_pkg::KIND_ECHO, tle_pkg::CH_DEL, 1'b1});
      end
    end else if (b == tle_pkg::CH_CR) begin
      for (int i = 0; i < line_len; i++)
        results_due.push_back('{tle_pkg::KIND_CMD, line_copy[i], 1'b0});
      results_due.push_back('{tle_pkg::KIND_EOL, 8'h00, 1'b1});
      line_len = 0;
    end else if (b == tle_pkg::CH_ESC) begin
      skip_phase = tle_pkg::ESC_ONE;
    end else if (line_len < LINE_DEPTH) begin
      line_copy[line_len] = b;
      line_len++;
      results_due.push_back('{tle_pkg::KIND_ECHO, b, 1'b1});
    end
  endfunction

  // Compare accepted results, then predict from the accepted input item
  always @(posedge clk) begin
    editor_result_t exp_res;
    if (rst) begin
      skip_phase = tle_pkg::ESC_OFF;
      line_len   = 0;
      results_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          $error("result with none expected: out_kind %0d out_byte %02h out_last %0b",
                 m_tuser, m_tdata, m_tlast);
          mismatches++;
        end else begin
          exp_res = results_due.pop_front();
          if (m_tuser !== exp_res.kind) begin
            $error("out_kind: expected %0d, actual %0d", exp_res.kind, m_tuser);
            mismatches++;
          end
          if (m_tdata !== exp_res.data) begin
            $error("out_byte: expected %02h, actual %02h", exp_res.data, m_tdata);
            mismatches++;
          end
          if (m_tlast !== exp_res.last) begin
            $error("out_last: expected %0b, actual %0b", exp_res.last, m_tlast);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready)
        edit_line(s_tdata);
    end
    queued = results_due.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for terminal_line_editor_unit: clock, reset, byte stimulus, verdict.
// Depends on tle_pkg, the editor RTL and line_editor_checker.
module tb;

  localparam int LINE_DEPTH  = tle_pkg::LINE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 75;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;   // [7:0] rx_byte
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;            // [7:0] out_byte
  logic [1:0] m_tuser;            // [1:0] out_kind
  logic       m_tlast;

  int fail_count;
  int pending;
  int cycle        = 0;
  int hold_until   = 0;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int items_sent   = 0;
  int items_target = 0;

  // Opening sequence: bit extremes, every control byte, escape skips, empty-line cases
  logic [7:0] opening_seq [24] = '{
    tle_pkg::CH_NUL, tle_pkg::CH_CR, tle_pkg::CH_BS, tle_pkg::CH_DEL,
    8'hFF, 8'h80, 8'h01, 8'h41,
    tle_pkg::CH_BS, tle_pkg::CH_DEL, 8'h7E, tle_pkg::CH_CR,
    tle_pkg::CH_ESC, 8'h35, 8'h39, tle_pkg::CH_NUL,
    8'h30, tle_pkg::CH_CR, 8'h55, tle_pkg::CH_ESC,
    tle_pkg::CH_ESC, tle_pkg::CH_ESC, 8'hAA, tle_pkg::CH_CR
  };

  terminal_line_editor_unit #(.LINE_DEPTH(LINE_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  line_editor_checker #(.LINE_DEPTH(LINE_DEPTH)) line_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle count and watchdog
  always @(posedge clk) begin
    cycle++;
    if (cycle > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off while hold_until is ahead
  always @(negedge clk) begin
    if (cycle < hold_until)
      m_tready <= 1'b0;
    else
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Offer one item; returns just after the falling edge following acceptance
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (b != tle_pkg::CH_NUL) items_sent++;
  endtask

  function automatic logic [7:0] digit_char();
    logic [7:0] d;
    d = tle_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    return d;
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b >= tle_pkg::CH_ZERO && b <= tle_pkg::CH_NINE);
    return b;
  endfunction

  // Mostly printable text, some erasing, a little of anything
  function automatic logic [7:0] line_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return 8'($urandom_range(8'h20, 8'h7E));
    if (r < 88) return ($urandom_range(0, 1) != 0) ? tle_pkg::CH_BS : tle_pkg::CH_DEL;
    return 8'($urandom_range(0, 255));
  endfunction

  // One random burst: a typed line, an escape sequence, erases, or raw noise
  task automatic send_burst();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      // occasional long lines run past the buffer
      len = ($urandom_range(0, 99) < 15) ? $urandom_range(28, 40) : $urandom_range(0, 10);
      repeat (len) send_byte(line_char());
      send_byte(tle_pkg::CH_CR);
    end else if (pick < 70) begin
      send_byte(tle_pkg::CH_ESC);
      repeat ($urandom_range(0, 3)) send_byte(digit_char());
      send_byte(non_digit());
      repeat ($urandom_range(0, 2)) send_byte(digit_char());
      send_byte(non_digit());
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 5))
        send_byte(($urandom_range(0, 1) != 0) ? tle_pkg::CH_BS : tle_pkg::CH_DEL);
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (opening_seq[i]) send_byte(opening_seq[i]);

    // Random phases: no idling, sender idle, receiver stalling, both light
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      // long receiver hold-off while items keep coming, so the input backs up
      if (ph == 0) hold_until = cycle + 400;
      items_target += PHASE_ITEMS;
      while (items_sent < items_target) send_burst();
    end

    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
